// ===== design/ftfa_pkg.sv =====
// ---------------------------------------------------------------------------
// Five-tuple flow accounting: shared package
// Table size, field widths, protocol codes, the transaction structs and the
// structs that run between the top level and the row of flow cells.
// ---------------------------------------------------------------------------
`default_nettype none

package ftfa_pkg;

  // Table size (1 .. 64 entries, as flow_slot is SLOT_W bits) and the width of an entry number
  localparam int FLOW_ENTRIES = 64;
  localparam int IDX_W        = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;

  // Field widths
  localparam int ADDR_W  = 32;
  localparam int PORT_W  = 16;
  localparam int PROTO_W = 2;
  localparam int LEN_W   = 16;
  localparam int TIME_W  = 32;
  localparam int SLOT_W  = 6;
  localparam int PKT_W   = 32;
  localparam int BYTE_W  = 40;

  // Protocol classes
  localparam logic [PROTO_W-1:0] PROTO_TCP   = 2'd0;
  localparam logic [PROTO_W-1:0] PROTO_UDP   = 2'd1;
  localparam logic [PROTO_W-1:0] PROTO_ICMP  = 2'd2;
  localparam logic [PROTO_W-1:0] PROTO_OTHER = 2'd3;

  // Input transaction
  typedef struct packed {
    logic [ADDR_W-1:0]  source_address;
    logic [ADDR_W-1:0]  destination_address;
    logic [PORT_W-1:0]  source_port;
    logic [PORT_W-1:0]  destination_port;
    logic [PROTO_W-1:0] protocol_class;
    logic [LEN_W-1:0]   packet_length;
    logic [TIME_W-1:0]  arrival_time;
  } item_t;

  // Result transaction
  typedef struct packed {
    logic [SLOT_W-1:0] flow_slot;
    logic              flow_created;
    logic              table_full;
    logic [PKT_W-1:0]  flow_packets;
    logic [BYTE_W-1:0] flow_bytes;
    logic [TIME_W-1:0] flow_first_time;
  } result_t;

  // Lookup key; ports packed source high, destination low
  typedef struct packed {
    logic [ADDR_W-1:0]   source_address;
    logic [ADDR_W-1:0]   destination_address;
    logic [2*PORT_W-1:0] ports;
    logic [PROTO_W-1:0]  protocol;
  } key_t;

  // Sequencing towards every cell
  typedef struct packed {
    logic compare;   // latch this cell's match bit
    logic update;    // write the cell (hit update or fill)
    logic any_hit;   // some cell in the row matched
  } cell_ctrl_t;

  // Status of one cell
  typedef struct packed {
    logic valid;
    logic match;
    logic free;      // lowest empty cell in the row
  } cell_stat_t;

  // Updated counters of a matching cell, zero elsewhere
  typedef struct packed {
    logic [PKT_W-1:0]  packets;
    logic [BYTE_W-1:0] bytes;
    logic [TIME_W-1:0] first_time;
  } cell_data_t;

endpackage

`default_nettype wire

// ===== design/ftfa_cell.sv =====
// ---------------------------------------------------------------------------
// Five-tuple flow accounting: flow cell
// Holds one table entry, compares it with the broadcast key, updates its
// saturating counters on a hit and fills itself on a miss when it is the
// lowest empty cell. Its valid bit goes on to the next cell in the row.
// ---------------------------------------------------------------------------
`default_nettype none

module ftfa_cell
  import ftfa_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire cell_ctrl_t        ctrl,
  input  wire key_t              key,
  input  wire logic [LEN_W-1:0]  len,
  input  wire logic [TIME_W-1:0] now,
  input  wire logic              prev_valid,
  output cell_stat_t             stat,
  output cell_data_t             data
);

  logic              valid;
  logic              match;
  key_t              entry_key;
  logic [PKT_W-1:0]  pkt_tally;
  logic [BYTE_W-1:0] byte_tally;
  logic [TIME_W-1:0] first_time;

  logic              free;
  logic [PKT_W-1:0]  pkt_tally_next;
  logic [BYTE_W:0]   byte_sum;
  logic [BYTE_W-1:0] byte_tally_next;

  // Entries fill from the bottom up, so the lowest empty cell is the one
  // whose lower neighbour is occupied
  assign free = !valid && prev_valid;

  // Saturating counter updates
  always_comb begin
    pkt_tally_next  = (pkt_tally == '1) ? pkt_tally : pkt_tally + PKT_W'(1);
    byte_sum        = {1'b0, byte_tally} + (BYTE_W + 1)'(len);
    byte_tally_next = byte_sum[BYTE_W] ? '1 : byte_sum[BYTE_W-1:0];
  end

  // Control: valid and match bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      match <= 1'b0;
    end else begin
      if (ctrl.compare) begin
        match <= valid && (entry_key == key);
      end else if (ctrl.update) begin
        match <= 1'b0;
      end
      if (ctrl.update && !ctrl.any_hit && free) begin
        valid <= 1'b1;
      end
    end
  end

  // Entry contents; the last-seen time is not kept since nothing reads it
  always_ff @(posedge clk) begin
    if (ctrl.update) begin
      if (match) begin
        pkt_tally  <= pkt_tally_next;
        byte_tally <= byte_tally_next;
      end else if (!ctrl.any_hit && free) begin
        entry_key  <= key;
        pkt_tally  <= PKT_W'(1);
        byte_tally <= BYTE_W'(len);
        first_time <= now;
      end
    end
  end

  assign stat.valid = valid;
  assign stat.match = match;
  assign stat.free  = free;

  // Readout, masked so the row can be OR-combined
  assign data.packets    = match ? pkt_tally_next  : '0;
  assign data.bytes      = match ? byte_tally_next : '0;
  assign data.first_time = match ? first_time      : '0;

endmodule

`default_nettype wire

// ===== design/five_tuple_flow_accounting_unit.sv =====
// ---------------------------------------------------------------------------
// Five-tuple flow accounting unit
// Exact-match flow table over a row of flow cells with saturating packet
// and byte counters.
// ---------------------------------------------------------------------------
// A packet summary is taken when start is high and busy is low. One result
// follows for every transaction, shown for a single cycle with done high;
// the receiver cannot stall it. Each packet passes a compare cycle that
// compares the key with all entries of the cell row and latches the match
// bits, then an update cycle that updates or fills the selected cell and
// registers the result. busy is high only in the compare cycle, so a new
// packet may be presented in the update cycle.
// Entries are filled lowest first and never freed; once all are in use a
// new flow is dropped with table_full set.
`default_nettype none

module five_tuple_flow_accounting_unit
  import ftfa_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  start,
  output logic       busy,
  input  wire item_t item,
  output logic       done,
  output result_t    result
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CMP  = 2'd1;
  localparam logic [1:0] ST_UPD  = 2'd2;

  logic [1:0]        state;
  logic [1:0]        state_next;
  logic              accept;

  key_t              key;
  logic [LEN_W-1:0]  len;
  logic [TIME_W-1:0] now;
  key_t              key_next;

  cell_ctrl_t        ctrl;
  cell_stat_t        stat [FLOW_ENTRIES];
  cell_data_t        data [FLOW_ENTRIES];
  logic [FLOW_ENTRIES-1:0] valid_vec;
  logic [FLOW_ENTRIES-1:0] match_vec;
  logic [FLOW_ENTRIES-1:0] free_vec;

  logic              any_hit;
  logic              any_free;
  cell_data_t        hit_data;
  logic [IDX_W-1:0]  slot_idx;
  result_t           result_next;

  assign busy   = (state == ST_CMP);
  assign accept = start && !busy;

  // Sequencer
  always_comb begin
    case (state)
      ST_IDLE: state_next = accept ? ST_CMP : ST_IDLE;
      ST_CMP:  state_next = ST_UPD;
      ST_UPD:  state_next = accept ? ST_CMP : ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Key build: ports carry no meaning for ICMP and other
  always_comb begin
    key_next.source_address      = item.source_address;
    key_next.destination_address = item.destination_address;
    key_next.protocol            = item.protocol_class;
    if (item.protocol_class == PROTO_ICMP || item.protocol_class == PROTO_OTHER) begin
      key_next.ports = '0;
    end else begin
      key_next.ports = {item.source_port, item.destination_port};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key <= key_next;
      len <= item.packet_length;
      now <= item.arrival_time;
    end
  end

  // Row of flow cells
  assign ctrl.compare = (state == ST_CMP);
  assign ctrl.update  = (state == ST_UPD);
  assign ctrl.any_hit = any_hit;

  for (genvar i = 0; i < FLOW_ENTRIES; i++) begin : g_cell
    logic prev_valid;
    if (i == 0) begin : g_first
      assign prev_valid = 1'b1;
    end else begin : g_rest
      assign prev_valid = stat[i-1].valid;
    end

    ftfa_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .key        (key),
      .len        (len),
      .now        (now),
      .prev_valid (prev_valid),
      .stat       (stat[i]),
      .data       (data[i])
    );

    assign valid_vec[i] = stat[i].valid;
    assign match_vec[i] = stat[i].match;
    assign free_vec[i]  = stat[i].free;
  end

  // Combine the row: at most one match and one free cell exist
  always_comb begin
    hit_data = '0;
    slot_idx = '0;
    for (int i = 0; i < FLOW_ENTRIES; i++) begin
      hit_data = hit_data | data[i];
      if (match_vec[i] || (free_vec[i] && match_vec == '0)) begin
        slot_idx = slot_idx | IDX_W'(i);
      end
    end
    any_hit  = |match_vec;
    any_free = |free_vec;
  end

  // Result selection
  always_comb begin
    result_next = '0;
    if (any_hit) begin
      result_next.flow_slot       = SLOT_W'(slot_idx);
      result_next.flow_packets    = hit_data.packets;
      result_next.flow_bytes      = hit_data.bytes;
      result_next.flow_first_time = hit_data.first_time;
    end else if (any_free) begin
      result_next.flow_slot       = SLOT_W'(slot_idx);
      result_next.flow_created    = 1'b1;
      result_next.flow_packets    = PKT_W'(1);
      result_next.flow_bytes      = BYTE_W'(len);
      result_next.flow_first_time = now;
    end else begin
      result_next.table_full      = 1'b1;
    end
  end

  // Result register and strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= (state == ST_UPD);
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_UPD) begin
      result <= result_next;
    end
  end

  // Checks
  a_done_after_update: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(state == ST_UPD))
    else $error("result strobe without an update cycle");

  a_single_match: assert property (@(posedge clk) disable iff (rst)
    $onehot0(match_vec))
    else $error("more than one entry matched");

  a_fill_contiguous: assert property (@(posedge clk) disable iff (rst)
    (valid_vec & (valid_vec + FLOW_ENTRIES'(1))) == '0)
    else $error("occupied entries not contiguous from the bottom");

  a_created_fills_one: assert property (@(posedge clk) disable iff (rst)
    (done && result.flow_created) |->
      ($countones(valid_vec) == $past($countones(valid_vec)) + 1))
    else $error("new flow did not occupy exactly one entry");

  a_no_fill_otherwise: assert property (@(posedge clk) disable iff (rst)
    (done && !result.flow_created) |-> $stable(valid_vec))
    else $error("entry occupied without a new flow");

endmodule

`default_nettype wire
